### hdl/slbs_pkg.sv
// ----------------------------------------------------------------------------
// Status LED blink sequencer package
// Shared request and result types, codes and the status color table.
// ----------------------------------------------------------------------------
package slbs_pkg;

    // Error codes carried by a request.
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_LOCAL  = 2'd1;
    localparam logic [1:0] ERR_REMOTE = 2'd2;
    localparam logic [1:0] ERR_OTHER  = 2'd3;

    // Status codes with a special meaning in the animation.
    localparam logic [2:0] STATUS_AMBER = 3'd0;
    localparam logic [2:0] STATUS_RED   = 3'd1;
    localparam logic [2:0] STATUS_GRN   = 3'd2;

    // Last phase of each animation cycle.
    localparam logic [3:0] PHASE_LAST_OK  = 4'd2;
    localparam logic [3:0] PHASE_LAST_ERR = 4'd12;

    // Prescaler reset value.
    localparam logic [7:0] TICK_DIVIDE_RESET = 8'd4;

    // Color levels.
    localparam logic [7:0] LVL_FULL  = 8'hff;
    localparam logic [7:0] LVL_AMBER = 8'h5f;
    localparam logic [7:0] LVL_OFF   = 8'h00;

    // One request entering the block.
    typedef struct packed {
        logic [2:0] status_code;
        logic [1:0] error_code;
        logic       identify_on;
        logic       tick_strobe;
    } t_led_req;

    // One color written to the LED.
    typedef struct packed {
        logic [7:0] red_level;
        logic [7:0] green_level;
        logic [7:0] blue_level;
    } t_led_rgb;

    // Result of the sequencer for one request.
    typedef struct packed {
        logic     written;
        t_led_rgb rgb;
    } t_anim_result;

    localparam t_led_rgb RGB_BLACK   = '{LVL_OFF,  LVL_OFF,  LVL_OFF};
    localparam t_led_rgb RGB_RED     = '{LVL_FULL, LVL_OFF,  LVL_OFF};
    localparam t_led_rgb RGB_GREEN   = '{LVL_OFF,  LVL_FULL, LVL_OFF};
    localparam t_led_rgb RGB_BLUE    = '{LVL_OFF,  LVL_OFF,  LVL_FULL};
    localparam t_led_rgb RGB_MAGENTA = '{LVL_FULL, LVL_OFF,  LVL_FULL};
    localparam t_led_rgb RGB_AMBER   = '{LVL_FULL, LVL_AMBER, LVL_OFF};

    // Color shown for each status code.
    function automatic t_led_rgb status_colour(input logic [2:0] status);
        t_led_rgb rgb;
        unique case (status)
            3'd0:    rgb = RGB_AMBER;
            3'd1:    rgb = RGB_RED;
            3'd2:    rgb = RGB_GREEN;
            3'd3:    rgb = RGB_RED;
            3'd4:    rgb = RGB_GREEN;
            default: rgb = RGB_BLACK;
        endcase
        return rgb;
    endfunction

endpackage

### hdl/status_led_blink_sequencer.sv
// ----------------------------------------------------------------------------
// Status LED blink sequencer
// Turns status, error and identify codes plus a tick strobe into LED colors.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while o_stall is low. A request
// is worked out in the cycle it is accepted; its color, if the phase writes
// one, goes to the result register that drives the output, or to the skid
// register behind it while the output stalls, so requests keep flowing;
// o_stall rises only when both registers hold colors. Requests without a
// tick, or whose tick does not complete the prescaler, give no color. The
// user must write tick_divide through the configuration port only while no
// request is in flight; the block does not enforce this. tick_divide resets to 4.
module status_led_blink_sequencer
    import slbs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Request channel
    input  logic       i_valid,
    output logic       o_stall,
    input  t_led_req   i_req,
    // Color channel
    output logic       o_valid,
    input  logic       i_stall,
    output t_led_rgb   o_rgb,
    // Configuration write channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    logic [7:0]   r_tick_divide;
    logic         r_out_valid;
    t_led_rgb     r_out_rgb;
    logic         r_skid_valid;
    t_led_rgb     r_skid_rgb;

    logic         accept;
    logic         out_free;
    logic         push;
    t_anim_result result;

    // Configuration register.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_divide <= TICK_DIVIDE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_tick_divide <= i_cfg_data;
        end
    end

    // Request handshake.
    assign o_stall = r_skid_valid;
    assign accept  = i_valid && !o_stall;

    slbs_anim u_anim (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_req         (i_req),
        .i_tick_divide (r_tick_divide),
        .o_result      (result)
    );

    // Output register with a skid entry behind it.
    assign out_free = !r_out_valid || !i_stall;
    assign push     = accept && result.written;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (out_free) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end
            end else if (push) begin
                if (out_free) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Color data moves with the valid bits above.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_free) begin
                r_out_rgb <= r_skid_rgb;
            end
        end else if (push) begin
            if (out_free) begin
                r_out_rgb <= result.rgb;
            end else begin
                r_skid_rgb <= result.rgb;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_rgb   = r_out_rgb;

endmodule

### hdl/slbs_anim.sv
// ----------------------------------------------------------------------------
// Status LED animation sequencer
// Holds the prescaler, phase and latched codes, and works out the color
// written by one request in the cycle it is accepted.
// ----------------------------------------------------------------------------
module slbs_anim
    import slbs_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_accept,
    input  t_led_req     i_req,
    input  logic [7:0]   i_tick_divide,
    output t_anim_result o_result
);

    logic [7:0] r_tick_count, n_tick_count;
    logic [3:0] r_phase, n_phase;
    logic [2:0] r_last_status;
    logic [1:0] r_last_error;

    logic [3:0] cur_phase;
    logic [7:0] count_inc;
    logic       step;
    logic [3:0] step_phase;
    logic       wr;
    t_led_rgb   rgb;
    t_led_rgb   stat_rgb;

    // A change of status or error restarts the animation.
    assign cur_phase = ((i_req.status_code != r_last_status) ||
                        (i_req.error_code != r_last_error)) ? 4'd0 : r_phase;

    // Prescaler: a tick steps the phase once the count plus one reaches or passes the divide value.
    assign count_inc = r_tick_count + 8'd1;
    assign step      = i_req.tick_strobe && !(count_inc < i_tick_divide);
    assign stat_rgb  = status_colour(i_req.status_code);

    // Color for the current phase and the phase that follows it.
    always_comb begin
        wr         = 1'b0;
        rgb        = RGB_BLACK;
        step_phase = 4'd0;
        if (i_req.error_code == ERR_NONE) begin
            step_phase = (cur_phase >= PHASE_LAST_OK) ? 4'd0 : cur_phase + 4'd1;
            if (cur_phase == 4'd0) begin
                wr  = 1'b1;
                rgb = stat_rgb;
            end else if (cur_phase <= PHASE_LAST_OK) begin
                // The identify flash overrides the off write of phase one.
                if (i_req.identify_on) begin
                    wr  = 1'b1;
                    rgb = RGB_BLUE;
                end else if (cur_phase == 4'd1 &&
                             (i_req.status_code == STATUS_RED ||
                              i_req.status_code == STATUS_GRN)) begin
                    wr  = 1'b1;
                    rgb = RGB_BLACK;
                end
            end
        end else begin
            step_phase = (cur_phase >= PHASE_LAST_ERR) ? 4'd0 : cur_phase + 4'd1;
            unique case (cur_phase)
                4'd0: begin
                    wr  = 1'b1;
                    rgb = stat_rgb;
                end
                4'd1, 4'd3, 4'd5, 4'd7, 4'd12: begin
                    wr  = 1'b1;
                    rgb = RGB_BLACK;
                end
                4'd2, 4'd4: begin
                    wr  = 1'b1;
                    rgb = RGB_RED;
                end
                4'd6: begin
                    wr = 1'b1;
                    unique case (i_req.error_code)
                        ERR_LOCAL:  rgb = RGB_GREEN;
                        ERR_REMOTE: rgb = RGB_BLUE;
                        default:    rgb = RGB_MAGENTA;
                    endcase
                end
                4'd8: begin
                    wr  = i_req.identify_on;
                    rgb = RGB_BLUE;
                end
                default: begin
                    wr  = 1'b0;
                    rgb = RGB_BLACK;
                end
            endcase
        end
    end

    // Next prescaler count and phase.
    always_comb begin
        n_tick_count = r_tick_count;
        n_phase      = cur_phase;
        if (i_req.tick_strobe) begin
            n_tick_count = step ? 8'd0 : count_inc;
        end
        if (step) begin
            n_phase = step_phase;
        end
    end

    assign o_result.written = step && wr;
    assign o_result.rgb     = rgb;

    // Sequencer state, updated once per accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count  <= 8'd0;
            r_phase       <= 4'd0;
            r_last_status <= STATUS_AMBER;
            r_last_error  <= ERR_NONE;
        end else if (i_accept) begin
            r_tick_count  <= n_tick_count;
            r_phase       <= n_phase;
            r_last_status <= i_req.status_code;
            r_last_error  <= i_req.error_code;
        end
    end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Status LED blink sequencer testbench
// Feeds status, error, identify and tick requests through the sequencer under
// a range of tick_divide settings. A local model of the prescaler and the
// normal and error blink cycles predicts each color, and every color that
// leaves the block is checked against it in order.
// ----------------------------------------------------------------------------
module testbench;
    import slbs_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int REPORT_LIMIT   = 10;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    t_led_req   i_req = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    t_led_rgb   o_rgb;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data = '0;

    status_led_blink_sequencer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_req       (i_req),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_rgb       (o_rgb),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Color shown for each status code.
    t_led_rgb status_palette [8] = '{RGB_AMBER, RGB_RED, RGB_GREEN, RGB_RED,
                                     RGB_GREEN, RGB_BLACK, RGB_BLACK, RGB_BLACK};

    // Model state of the sequencer.
    logic [7:0] divide_setting = TICK_DIVIDE_RESET;
    logic [7:0] tick_tally = '0;
    logic [3:0] blink_phase = '0;
    logic [2:0] seen_status = STATUS_AMBER;
    logic [1:0] seen_error = ERR_NONE;

    t_led_req pending_requests [$];
    t_led_rgb colours_due [$];

    bit idling_on = 1'b1;
    int gap_left = 0;
    int stall_left = 0;
    int faults = 0;
    int requests_sent = 0;
    int colours_checked = 0;
    int divide_writes = 0;
    int stuck_cycles = 0;
    t_led_rgb want_rgb;

    // Clock with a 20 unit period.
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_led_req mk_req(input logic [2:0] status, input logic [1:0] error,
                                        input logic ident, input logic tick);
        t_led_req r;
        r.status_code = status;
        r.error_code  = error;
        r.identify_on = ident;
        r.tick_strobe = tick;
        return r;
    endfunction

    task automatic log_fault(input string msg);
        faults++;
        if (faults <= REPORT_LIMIT) begin
            $display("MISMATCH: %s", msg);
        end
    endtask

    task automatic check_level(input string name, input logic [7:0] got,
                               input logic [7:0] exp);
        if (got !== exp) begin
            log_fault($sformatf("%s expected %02h actual %02h", name, exp, got));
        end
    endtask

    // Advance the prescaler and the blink cycle for one request and queue the
    // color it writes, if any.
    task automatic predict_colour(input t_led_req r);
        t_led_rgb rgb;
        bit lit;
        lit = 1'b0;
        rgb = RGB_BLACK;
        if (r.status_code != seen_status) begin
            seen_status = r.status_code;
            blink_phase = '0;
        end
        if (r.error_code != seen_error) begin
            seen_error = r.error_code;
            blink_phase = '0;
        end
        if (r.tick_strobe) begin
            tick_tally = tick_tally + 8'd1;
            if (tick_tally >= divide_setting) begin
                tick_tally = '0;
                if (seen_error == ERR_NONE) begin
                    if (blink_phase == 4'd0) begin
                        lit = 1'b1;
                        rgb = status_palette[seen_status];
                    end else if (blink_phase <= PHASE_LAST_OK) begin
                        // Red and green statuses blink off; identify overrides.
                        if (blink_phase == 4'd1 &&
                            (seen_status == STATUS_RED || seen_status == STATUS_GRN)) begin
                            lit = 1'b1;
                            rgb = RGB_BLACK;
                        end
                        if (r.identify_on) begin
                            lit = 1'b1;
                            rgb = RGB_BLUE;
                        end
                    end
                    blink_phase = (blink_phase >= PHASE_LAST_OK) ? 4'd0 : blink_phase + 4'd1;
                end else begin
                    case (blink_phase)
                        4'd0: begin
                            lit = 1'b1;
                            rgb = status_palette[seen_status];
                        end
                        4'd1, 4'd3, 4'd5, 4'd7, 4'd12: begin
                            lit = 1'b1;
                            rgb = RGB_BLACK;
                        end
                        4'd2, 4'd4: begin
                            lit = 1'b1;
                            rgb = RGB_RED;
                        end
                        4'd6: begin
                            lit = 1'b1;
                            case (seen_error)
                                ERR_LOCAL:  rgb = RGB_GREEN;
                                ERR_REMOTE: rgb = RGB_BLUE;
                                default:    rgb = RGB_MAGENTA;
                            endcase
                        end
                        4'd8: begin
                            if (r.identify_on) begin
                                lit = 1'b1;
                                rgb = RGB_BLUE;
                            end
                        end
                        default: ;
                    endcase
                    blink_phase = (blink_phase >= PHASE_LAST_ERR) ? 4'd0 : blink_phase + 4'd1;
                end
            end
        end
        if (lit) begin
            colours_due.push_back(rgb);
        end
    endtask

    // Request driver: predicts each accepted request and presents the next.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_colour(i_req);
                requests_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    i_valid <= 1'b1;
                    i_req <= pending_requests.pop_front();
                    if (idling_on && $urandom_range(0, 5) == 0) begin
                        gap_left = $urandom_range(1, 10);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Color monitor: checks each accepted color and stalls in bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                colours_checked++;
                if (colours_due.size() == 0) begin
                    log_fault($sformatf("color %06h arrived with none expected", o_rgb));
                end else begin
                    want_rgb = colours_due.pop_front();
                    check_level("red_level", o_rgb.red_level, want_rgb.red_level);
                    check_level("green_level", o_rgb.green_level, want_rgb.green_level);
                    check_level("blue_level", o_rgb.blue_level, want_rgb.blue_level);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (idling_on && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 9);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("status_led_blink_sequencer verification failed");
                $finish;
            end
        end
    end

    // Wait until every request is in and every color is out, then let the
    // block settle.
    task automatic drain();
        do begin
            @(negedge i_clk);
        end while (pending_requests.size() != 0 || i_valid || colours_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_divide(input logic [7:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) begin
                break;
            end
        end
        i_cfg_valid <= 1'b0;
        divide_setting = value;
        divide_writes++;
    endtask

    // Mostly steady runs of one status and error with random identify and
    // ticks, so that whole blink cycles play out; the rest is random noise.
    task automatic load_random(input int count);
        t_led_req r;
        logic [2:0] status;
        logic [1:0] error;
        logic ident;
        int run;
        while (count > 0) begin
            if ($urandom_range(0, 5) == 0) begin
                r = t_led_req'(7'($urandom_range(0, 127)));
                pending_requests.push_back(r);
                count--;
            end else begin
                status = 3'($urandom_range(0, 7));
                error = ($urandom_range(0, 2) == 0) ? ERR_NONE : 2'($urandom_range(0, 3));
                ident = 1'($urandom_range(0, 1));
                run = $urandom_range(4, 60);
                repeat (run) begin
                    r = mk_req(status, error,
                               ($urandom_range(0, 7) == 0) ? ~ident : ident,
                               ($urandom_range(0, 3) != 0));
                    pending_requests.push_back(r);
                    count--;
                end
            end
        end
    endtask

    // Stimulus sequence.
    initial begin
        logic [7:0] divide_plan [8];
        int item_plan [8];
        divide_plan = '{8'd2, 8'd0, 8'd3, 8'd255, 8'd5, 8'd1, 8'd1, 8'd1};
        item_plan = '{110, 90, 110, 60, 80, 110, 80, 60};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset prescaler: amber on the fourth tick, then a held request
        // without a tick.
        repeat (5) pending_requests.push_back(mk_req(STATUS_AMBER, ERR_NONE, 1'b1, 1'b1));
        pending_requests.push_back(mk_req(STATUS_AMBER, ERR_NONE, 1'b1, 1'b0));
        drain();
        write_divide(8'd1);

        // Red blinks off, green with identify turns blue, then one full error
        // cycle, then an error change without a tick.
        repeat (3) pending_requests.push_back(mk_req(STATUS_RED, ERR_NONE, 1'b0, 1'b1));
        repeat (3) pending_requests.push_back(mk_req(STATUS_GRN, ERR_NONE, 1'b1, 1'b1));
        repeat (13) pending_requests.push_back(mk_req(3'd7, ERR_LOCAL, 1'b1, 1'b1));
        pending_requests.push_back(mk_req(3'd7, ERR_OTHER, 1'b0, 1'b0));
        drain();

        // Random phases. Divide zero steps on every tick, and the drop from
        // 255 to 5 lands below a tally that has already climbed past it.
        for (int i = 0; i < 8; i++) begin
            if (i == 6) begin
                divide_plan[i] = 8'($urandom_range(1, 8));
            end
            if (i == 7) begin
                idling_on = 1'b0;
            end
            write_divide(divide_plan[i]);
            load_random(item_plan[i]);
            drain();
        end

        $display("Sent %0d requests and checked %0d colors", requests_sent, colours_checked);
        $display("Covered %0d divide settings, including 0, 1 and 255", divide_writes);
        if (faults == 0 && colours_due.size() == 0) begin
            $display("status_led_blink_sequencer verification clean");
        end else begin
            $display("%0d mismatches, %0d colors still expected", faults, colours_due.size());
            $display("status_led_blink_sequencer verification failed");
        end
        $finish;
    end

endmodule
